[src/pdll_pkg.sv]
// ----------------------------------------------------------------------------
// pdll_pkg
// Shared types and codes for the positional doubly linked list.
// ----------------------------------------------------------------------------
package pdll_pkg;

    localparam int POOL_DEPTH = 64;
    localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int LEN_W      = 7;
    localparam int VAL_W      = 32;

    localparam logic [3:0] CMD_CLEAR    = 4'd0;
    localparam logic [3:0] CMD_INS_FRNT = 4'd1;
    localparam logic [3:0] CMD_INS_AT   = 4'd2;
    localparam logic [3:0] CMD_INS_BACK = 4'd3;
    localparam logic [3:0] CMD_DEL_FRNT = 4'd4;
    localparam logic [3:0] CMD_DEL_AT   = 4'd5;
    localparam logic [3:0] CMD_DEL_BACK = 4'd6;
    localparam logic [3:0] CMD_COUNT    = 4'd7;
    localparam logic [3:0] CMD_SEARCH   = 4'd8;
    localparam logic [3:0] CMD_RD_FWD   = 4'd9;
    localparam logic [3:0] CMD_RD_BACK  = 4'd10;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    localparam logic [2:0] OP_HOLD = 3'd0;
    localparam logic [2:0] OP_INS  = 3'd1;
    localparam logic [2:0] OP_DEL  = 3'd2;
    localparam logic [2:0] OP_ROTL = 3'd3;
    localparam logic [2:0] OP_ROTR = 3'd4;

    typedef struct packed {
        logic [2:0]       op;
        logic [IDX_W-1:0] k;
        logic [IDX_W-1:0] tap;
        logic [LEN_W-1:0] len;
        logic [VAL_W-1:0] val;
    } pdll_ctl_t;

endpackage

[src/positional_doubly_linked_list_top.sv]
// ----------------------------------------------------------------------------
// positional_doubly_linked_list_top
// Bounded list of signed 32-bit values held in order in a row of cells.
// ----------------------------------------------------------------------------
// Clear, insert, delete and count each give one beat. Search and reads
// walk the list by rotating the cell row one slot per cycle while the
// output slot is free: a search accepts, then takes one step per element,
// and gives one beat; a read gives one beat per element, one per cycle
// while out_ready stays high. The list is stored in element order, so
// inserts and deletes shift all cells at once; the walk over the row sets
// the cost of search and read.
module positional_doubly_linked_list_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  command,
    input  logic [6:0]  position,
    input  logic signed [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic signed [31:0] item_value,
    output logic [6:0]  length,
    output logic        found,
    output logic        last
);
    import pdll_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic             state_reg, state_next;
    logic [3:0]       cmd_reg, cmd_next;
    logic [VAL_W-1:0] key_reg, key_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic             hit_reg, hit_next;
    logic [LEN_W-1:0] len_reg, len_next;

    logic             ov_reg, ov_next;
    logic [1:0]       st_reg, st_next;
    logic [VAL_W-1:0] iv_reg, iv_next;
    logic [LEN_W-1:0] ln_reg, ln_next;
    logic             fd_reg, fd_next;
    logic             ls_reg, ls_next;

    logic [VAL_W-1:0] cell_val [POOL_DEPTH];
    logic [VAL_W-1:0] cell_tap [POOL_DEPTH];
    logic [VAL_W-1:0] tap_or;
    pdll_ctl_t        ctl;

    logic             slot_free, accept, step, final_step, eq;
    logic [LEN_W:0]   pos_w, len_w;

    assign slot_free = !ov_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign step      = (state_reg == S_WALK) && slot_free;
    assign final_step = step && (cnt_reg == len_reg - LEN_W'(1));
    assign eq        = (cell_val[0] == key_reg);
    assign pos_w     = {1'b0, position};
    assign len_w     = {1'b0, len_reg};

    always_comb
    begin
        tap_or = '0;
        for (int i = 0; i < POOL_DEPTH; i++)
            tap_or = tap_or | cell_tap[i];
    end

    genvar g;
    generate
        for (g = 0; g < POOL_DEPTH; g++)
        begin : g_cell
            pdll_cell u_cell (
                .clk       (clk),
                .idx       (IDX_W'(g)),
                .ctl       (ctl),
                .left_val  ((g == 0) ? '0 : cell_val[(g == 0) ? 0 : g-1]),
                .right_val ((g == POOL_DEPTH-1) ? '0
                            : cell_val[(g == POOL_DEPTH-1) ? g : g+1]),
                .head_val  (cell_val[0]),
                .tail_val  (tap_or),
                .cur_val   (cell_val[g]),
                .tap_val   (cell_tap[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        cnt_next   = cnt_reg;
        hit_next   = hit_reg;
        len_next   = len_reg;
        ov_next    = ov_reg && !out_ready;
        st_next    = st_reg;
        iv_next    = iv_reg;
        ln_next    = ln_reg;
        fd_next    = fd_reg;
        ls_next    = ls_reg;
        ctl.op     = OP_HOLD;
        ctl.k      = '0;
        ctl.tap    = '0;
        ctl.len    = len_reg;
        ctl.val    = value;

        if (state_reg == S_WALK)
        begin
            ctl.tap = IDX_W'(len_reg - LEN_W'(1));
            if (step)
            begin
                ctl.op   = (cmd_reg == CMD_RD_BACK) ? OP_ROTR : OP_ROTL;
                cnt_next = cnt_reg + LEN_W'(1);
                hit_next = hit_reg || eq;
                if (cmd_reg != CMD_SEARCH)
                begin
                    ov_next = 1'b1;
                    st_next = ST_OK;
                    iv_next = (cmd_reg == CMD_RD_BACK) ? tap_or : cell_val[0];
                    ln_next = len_reg;
                    fd_next = 1'b0;
                    ls_next = final_step;
                end
                else if (final_step)
                begin
                    ov_next = 1'b1;
                    st_next = ST_OK;
                    iv_next = '0;
                    ln_next = len_reg;
                    fd_next = hit_reg || eq;
                    ls_next = 1'b1;
                end
                if (final_step)
                    state_next = S_IDLE;
            end
        end
        else if (accept)
        begin
            st_next = ST_OK;
            iv_next = '0;
            fd_next = 1'b0;
            ls_next = 1'b1;
            ov_next = 1'b1;
            unique case (command)
                CMD_CLEAR:
                    len_next = '0;
                CMD_INS_FRNT, CMD_INS_AT, CMD_INS_BACK:
                begin
                    if (len_reg == LEN_W'(POOL_DEPTH))
                        st_next = ST_FULL;
                    else if (command == CMD_INS_AT &&
                             (pos_w == '0 || pos_w > len_w + 8'd1))
                        st_next = ST_BADPOS;
                    else
                    begin
                        ctl.op = OP_INS;
                        if (command == CMD_INS_AT)
                            ctl.k = IDX_W'(position - 7'd1);
                        else if (command == CMD_INS_BACK)
                            ctl.k = IDX_W'(len_reg);
                        len_next = len_reg + LEN_W'(1);
                    end
                end
                CMD_DEL_FRNT, CMD_DEL_AT, CMD_DEL_BACK:
                begin
                    if (len_reg == '0)
                        st_next = ST_EMPTY;
                    else if (command == CMD_DEL_AT &&
                             (pos_w == '0 || pos_w > len_w))
                        st_next = ST_BADPOS;
                    else
                    begin
                        ctl.op = OP_DEL;
                        if (command == CMD_DEL_AT)
                            ctl.k = IDX_W'(position - 7'd1);
                        else if (command == CMD_DEL_BACK)
                            ctl.k = IDX_W'(len_reg - LEN_W'(1));
                        ctl.tap  = ctl.k;
                        iv_next  = tap_or;
                        len_next = len_reg - LEN_W'(1);
                    end
                end
                CMD_COUNT:
                    if (len_reg == '0)
                        st_next = ST_EMPTY;
                CMD_SEARCH, CMD_RD_FWD, CMD_RD_BACK:
                begin
                    if (len_reg == '0)
                        st_next = ST_EMPTY;
                    else
                    begin
                        ov_next    = ov_reg && !out_ready;
                        state_next = S_WALK;
                        cmd_next   = command;
                        key_next   = value;
                        cnt_next   = '0;
                        hit_next   = 1'b0;
                    end
                end
                default: st_next = ST_OK;
            endcase
            ln_next = len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
            hit_reg   <= 1'b0;
            cmd_reg   <= CMD_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
            hit_reg   <= hit_next;
            cmd_reg   <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        st_reg  <= st_next;
        iv_reg  <= iv_next;
        ln_reg  <= ln_next;
        fd_reg  <= fd_next;
        ls_reg  <= ls_next;
    end

    assign out_valid  = ov_reg;
    assign status     = st_reg;
    assign item_value = iv_reg;
    assign length     = ln_reg;
    assign found      = fd_reg;
    assign last       = ls_reg;

endmodule

[src/pdll_cell.sv]
// ----------------------------------------------------------------------------
// pdll_cell
// One list slot; shifts or rotates with its neighbors on a broadcast op.
// ----------------------------------------------------------------------------
module pdll_cell (
    input  logic                      clk,
    input  logic [pdll_pkg::IDX_W-1:0] idx,
    input  pdll_pkg::pdll_ctl_t       ctl,
    input  logic [pdll_pkg::VAL_W-1:0] left_val,
    input  logic [pdll_pkg::VAL_W-1:0] right_val,
    input  logic [pdll_pkg::VAL_W-1:0] head_val,
    input  logic [pdll_pkg::VAL_W-1:0] tail_val,
    output logic [pdll_pkg::VAL_W-1:0] cur_val,
    output logic [pdll_pkg::VAL_W-1:0] tap_val
);
    import pdll_pkg::*;

    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] val_next;
    logic [LEN_W-1:0] idx_w;
    logic [LEN_W-1:0] lm1;

    assign idx_w = LEN_W'(idx);
    assign lm1   = ctl.len - LEN_W'(1);

    always_comb
    begin
        val_next = val_reg;
        case (ctl.op)
            OP_INS:
            begin
                if (idx == ctl.k)
                    val_next = ctl.val;
                else if (idx > ctl.k)
                    val_next = left_val;
            end
            OP_DEL:
            begin
                if (idx >= ctl.k)
                    val_next = right_val;
            end
            OP_ROTL:
            begin
                if (idx_w < lm1)
                    val_next = right_val;
                else if (idx_w == lm1)
                    val_next = head_val;
            end
            OP_ROTR:
            begin
                if (idx_w == '0)
                    val_next = tail_val;
                else if (idx_w <= lm1)
                    val_next = left_val;
            end
            default: val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign cur_val = val_reg;
    assign tap_val = (idx == ctl.tap) ? val_reg : '0;

endmodule

[src/pdll_checker.sv]
// ----------------------------------------------------------------------------
// pdll_checker
// Port-level checks for the positional doubly linked list.
// ----------------------------------------------------------------------------
module pdll_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [31:0] item_value,
    input logic [6:0]  length,
    input logic        found,
    input logic        last
);
    import pdll_pkg::*;

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last)
        else $error("error beat without last");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == ST_OK && item_value == '0 && last)
        else $error("found on bad beat");

    a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> length <= 7'(POOL_DEPTH))
        else $error("length over pool depth");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(item_value) && $stable(last))
        else $error("stalled beat changed");

endmodule

bind positional_doubly_linked_list_top pdll_checker u_pdll_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .item_value (item_value),
    .length     (length),
    .found      (found),
    .last       (last)
);
